FILE: rtl/lspq_pkg.sv
// Shared types and codes of the linear scan priority queue.
`default_nettype none
package lspq_pkg;

  // Operation carried by an input word.
  typedef enum logic {
    OpInsert  = 1'b0,
    OpExtract = 1'b1
  } lspq_op_e;

  // Status carried by a result word.
  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StExtracted = 2'd1,
    StEmpty     = 2'd2,
    StFull      = 2'd3
  } lspq_status_e;

  localparam int unsigned PriW = 16;
  localparam int unsigned TagW = 16;

endpackage
`default_nettype wire

FILE: rtl/lspq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module lspq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/linear_scan_priority_queue.sv
// Top level of the linear scan priority queue: control FSM around one entry RAM.
`default_nettype none
// Priority queue of up to CAPACITY entries (16-bit priority, 16-bit tag) kept
// in insertion order in one RAM. A word is accepted on a rising edge with
// start high and busy low. Every word yields exactly one result word, shown on
// the result ports for exactly one cycle with done_o high; the receiver cannot
// stall, so capture it on that cycle. An insert, an insert on a full queue
// and an extract on an empty queue are handled in idle: the result appears
// on the next cycle and busy stays low, so words may be issued back to back.
// An extract on a queue of n entries keeps busy high while it scans all n
// entries, one RAM read per cycle, then closes up the n-1-w entries behind the
// winner at position w, one read and one write per cycle. The result word
// is shown in the first cycle with busy low again, and a new word may be
// accepted in that same cycle. Ties go to the earliest inserted entry.
module linear_scan_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation_i,
  input  wire logic [15:0] item_priority_i,
  input  wire logic [15:0] item_tag_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [15:0]      out_priority_o,
  output logic [15:0]      out_tag_o,
  output logic             queue_empty_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = lspq_pkg::PriW + lspq_pkg::TagW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             count_q;
  logic [AW-1:0]             idx_q;       // index of the entry whose data arrives
  logic [AW-1:0]             best_idx_q;
  logic [lspq_pkg::PriW-1:0] best_pri_q;
  logic [lspq_pkg::TagW-1:0] best_tag_q;

  logic                      done_q;
  logic [1:0]                status_q;
  logic [lspq_pkg::PriW-1:0] out_pri_q;
  logic [lspq_pkg::TagW-1:0] out_tag_q;
  logic                      empty_q;

  // RAM port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic [lspq_pkg::PriW-1:0] rd_pri;
  logic [lspq_pkg::TagW-1:0] rd_tag;
  logic                      take;
  logic [AW-1:0]             cand_idx;
  logic [lspq_pkg::PriW-1:0] cand_pri;
  logic [lspq_pkg::TagW-1:0] cand_tag;
  logic                      idx_last;
  logic                      cand_last;
  logic                      full;

  assign rd_pri = ram_rdata[DW-1:lspq_pkg::TagW];
  assign rd_tag = ram_rdata[lspq_pkg::TagW-1:0];

  // Strictly greater replaces the running best, so the oldest wins a tie.
  assign take     = (idx_q == '0) || (rd_pri > best_pri_q);
  assign cand_idx = take ? idx_q  : best_idx_q;
  assign cand_pri = take ? rd_pri : best_pri_q;
  assign cand_tag = take ? rd_tag : best_tag_q;

  assign idx_last  = (CW'(idx_q) + CW'(1)) == count_q;
  assign cand_last = (CW'(cand_idx) + CW'(1)) == count_q;
  assign full      = count_q == CW'(CAPACITY);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = {item_priority_i, item_tag_i};
    ram_raddr = idx_q + AW'(1);
    unique case (state_q)
      StIdle: begin
        // Read the oldest entry so the scan can start on the next cycle.
        ram_raddr = '0;
        if (start && (operation_i == lspq_pkg::OpInsert) && !full) begin
          ram_we = 1'b1;
        end
      end
      StScan: begin
        // On the last compare, fetch the entry behind the winner.
        if (idx_last) begin
          ram_raddr = cand_idx + AW'(1);
        end
      end
      StShift: begin
        // Move each later entry one place toward the head.
        ram_we    = 1'b1;
        ram_waddr = idx_q - AW'(1);
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lspq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      idx_q      <= '0;
      best_idx_q <= '0;
      best_pri_q <= '0;
      best_tag_q <= '0;
      done_q     <= 1'b0;
      status_q   <= lspq_pkg::StInserted;
      out_pri_q  <= '0;
      out_tag_q  <= '0;
      empty_q    <= 1'b1;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            if (operation_i == lspq_pkg::OpInsert) begin
              done_q    <= 1'b1;
              out_pri_q <= '0;
              out_tag_q <= '0;
              empty_q   <= 1'b0;
              if (full) begin
                status_q <= lspq_pkg::StFull;
              end else begin
                status_q <= lspq_pkg::StInserted;
                count_q  <= count_q + CW'(1);
              end
            end else if (count_q == '0) begin
              done_q    <= 1'b1;
              status_q  <= lspq_pkg::StEmpty;
              out_pri_q <= '0;
              out_tag_q <= '0;
              empty_q   <= 1'b1;
            end else begin
              state_q <= StScan;
              idx_q   <= '0;
            end
          end
        end
        StScan: begin
          best_idx_q <= cand_idx;
          best_pri_q <= cand_pri;
          best_tag_q <= cand_tag;
          if (!idx_last) begin
            idx_q <= idx_q + AW'(1);
          end else if (cand_last) begin
            // Winner is the newest entry: drop it without moving anything.
            state_q   <= StIdle;
            done_q    <= 1'b1;
            status_q  <= lspq_pkg::StExtracted;
            out_pri_q <= cand_pri;
            out_tag_q <= cand_tag;
            empty_q   <= count_q == CW'(1);
            count_q   <= count_q - CW'(1);
          end else begin
            state_q <= StShift;
            idx_q   <= cand_idx + AW'(1);
          end
        end
        StShift: begin
          if (idx_last) begin
            state_q   <= StIdle;
            done_q    <= 1'b1;
            status_q  <= lspq_pkg::StExtracted;
            out_pri_q <= best_pri_q;
            out_tag_q <= best_tag_q;
            empty_q   <= count_q == CW'(1);
            count_q   <= count_q - CW'(1);
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy           = state_q != StIdle;
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_priority_o = out_pri_q;
  assign out_tag_o      = out_tag_q;
  assign queue_empty_o  = empty_q;

endmodule
`default_nettype wire

FILE: rtl/lspq_checker.sv
// Port-level checks of the linear scan priority queue and their bind.
`default_nettype none
module lspq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        operation_i,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] out_priority_o,
  input wire logic [15:0] out_tag_o,
  input wire logic        queue_empty_o
);

  // An insert reports inserted or full in the next cycle, with busy still low.
  a_insert_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == lspq_pkg::OpInsert)) |=>
      (done_o && !busy &&
       ((status_o == lspq_pkg::StInserted) || (status_o == lspq_pkg::StFull))))
    else $error("insert did not finish in one cycle");

  // Only an extract returns a nonzero entry.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != lspq_pkg::StExtracted)) |->
      ((out_priority_o == '0) && (out_tag_o == '0)))
    else $error("nonzero fields on a result that carries no entry");

  // Empty flag agrees with the status.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == lspq_pkg::StEmpty)) |-> queue_empty_o)
    else $error("extract on empty queue without empty flag");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((status_o == lspq_pkg::StFull) ||
                (status_o == lspq_pkg::StInserted))) |-> !queue_empty_o)
    else $error("empty flag after an insert");

  // Busy only rises right after an accepted word.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !busy)
    else $error("busy rose without an accepted word");

endmodule

bind linear_scan_priority_queue lspq_checker u_lspq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .operation_i    (operation_i),
  .done_o         (done_o),
  .status_o       (status_o),
  .out_priority_o (out_priority_o),
  .out_tag_o      (out_tag_o),
  .queue_empty_o  (queue_empty_o)
);
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for the linear scan priority queue: random traffic against a shadow queue.
module tb_top;

  localparam int unsigned Capacity = 16;
  // Longest extract scans every entry and then shifts the rest; add margin for the result.
  localparam int unsigned DrainCycles = 2 * Capacity + 8;
  localparam int unsigned RandomItems = 525;

  // One command word as the driver presents it.
  typedef struct packed {
    lspq_pkg::lspq_op_e op;
    logic [15:0]        prio;
    logic [15:0]        tag;
  } cmd_word_t;

  // One result word as the queue should report it.
  typedef struct packed {
    lspq_pkg::lspq_status_e status;
    logic [15:0]            prio;
    logic [15:0]            tag;
    logic                   empty;
  } queue_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        operation_i = 1'b0;
  logic [15:0] item_priority_i = '0;
  logic [15:0] item_tag_i = '0;
  logic        busy;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] out_priority_o;
  logic [15:0] out_tag_o;
  logic        queue_empty_o;

  cmd_word_t     cmd_backlog[$];
  queue_result_t expected_results[$];
  int unsigned   error_count = 0;
  int unsigned   issued_count = 0;
  int unsigned   gap_left = 0;
  cmd_word_t     next_cmd;

  // Shadow copy of the queue contents, oldest entry at index 0.
  logic [15:0] shadow_prio[Capacity];
  logic [15:0] shadow_tag[Capacity];
  int unsigned shadow_count = 0;

  linear_scan_priority_queue #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .item_priority_i(item_priority_i),
    .item_tag_i     (item_tag_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_tag_o      (out_tag_o),
    .queue_empty_o  (queue_empty_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Append one command word to the end of the backlog.
  function automatic void append_cmd(lspq_pkg::lspq_op_e op, logic [15:0] prio,
                                     logic [15:0] tag);
    cmd_word_t w;
    w.op = op;
    w.prio = prio;
    w.tag = tag;
    cmd_backlog.insert(cmd_backlog.size(), w);
  endfunction

  // Queue the result that a taken word must produce.
  function automatic void note_result(queue_result_t res);
    expected_results.insert(expected_results.size(), res);
  endfunction

  // Apply one command to the shadow queue and return the result it must give.
  function automatic queue_result_t serve_command(lspq_pkg::lspq_op_e op,
                                                  logic [15:0] prio,
                                                  logic [15:0] tag);
    queue_result_t res;
    int unsigned   best;
    res = '{status: lspq_pkg::StInserted, prio: '0, tag: '0, empty: 1'b0};
    best = 0;
    if (op == lspq_pkg::OpInsert) begin
      if (shadow_count >= Capacity) begin
        res.status = lspq_pkg::StFull;
      end else begin
        shadow_prio[shadow_count] = prio;
        shadow_tag[shadow_count] = tag;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = lspq_pkg::StEmpty;
    end else begin
      // Strict greater-than keeps the earliest entry on a tie.
      for (int unsigned i = 1; i < shadow_count; i++) begin
        if (shadow_prio[i] > shadow_prio[best]) begin
          best = i;
        end
      end
      res.status = lspq_pkg::StExtracted;
      res.prio = shadow_prio[best];
      res.tag = shadow_tag[best];
      // Close up the entries behind the winner to keep insertion order.
      for (int unsigned i = best; i + 1 < shadow_count; i++) begin
        shadow_prio[i] = shadow_prio[i + 1];
        shadow_tag[i] = shadow_tag[i + 1];
      end
      shadow_count--;
    end
    res.empty = (shadow_count == 0);
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Priority mix: full range, clustered low values for ties, and values near the top.
  function automatic logic [15:0] pick_priority();
    logic [15:0] p;
    case ($urandom_range(0, 3))
      0: p = 16'($urandom_range(0, 7));
      1: p = 16'hfff8 + 16'($urandom_range(0, 7));
      default: p = 16'($urandom);
    endcase
    return p;
  endfunction

  // Driver: score the word taken at this edge, then hold, idle or present the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        note_result(
          serve_command(lspq_pkg::lspq_op_e'(operation_i), item_priority_i, item_tag_i));
      end
      // Hold the current word until the queue takes it.
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (cmd_backlog.size() != 0 && cmd_backlog.size() > 40 &&
                     (issued_count / 32) % 4 != 3 && $urandom_range(0, 3) == 0) begin
          // Open an idle burst; it lands on whatever phase the queue is in.
          gap_left <= $urandom_range(0, 4);
          start <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          next_cmd = cmd_backlog.pop_front();
          operation_i <= next_cmd.op;
          item_priority_i <= next_cmd.prio;
          item_tag_i <= next_cmd.tag;
          start <= 1'b1;
          issued_count <= issued_count + 1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed word must match the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status 0x%0h", $time,
                 status_o);
        error_count++;
      end else begin
        check_field("status", expected_results[0].status, status_o);
        check_field("out_priority", expected_results[0].prio, out_priority_o);
        check_field("out_tag", expected_results[0].tag, out_tag_o);
        check_field("queue_empty", expected_results[0].empty, queue_empty_o);
        void'(expected_results.pop_front());
      end
    end
  end

  // Build the command list, release reset, then wait for the queue to drain.
  initial begin
    logic [15:0] fill_prio[16];
    int unsigned phase_left;
    int unsigned insert_pct;
    cmd_word_t   w;
    fill_prio = '{16'h1234, 16'h0001, 16'h8000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000,
                  16'hffff, 16'h0000, 16'hfffe, 16'h8000, 16'h0002, 16'hffff, 16'h5555,
                  16'haaaa, 16'h8000};
    phase_left = 0;
    insert_pct = 50;

    // Directed: extract on empty, both field extremes, drain back to empty.
    append_cmd(lspq_pkg::OpExtract, 16'h0000, 16'h0000);
    append_cmd(lspq_pkg::OpInsert, 16'hffff, 16'hffff);
    append_cmd(lspq_pkg::OpInsert, 16'h0000, 16'h0000);
    append_cmd(lspq_pkg::OpExtract, 16'hffff, 16'hffff);
    append_cmd(lspq_pkg::OpExtract, 16'h0000, 16'h0000);
    append_cmd(lspq_pkg::OpExtract, 16'hffff, 16'hffff);
    // Fill to capacity with repeated priorities so ties at the top get resolved.
    for (int i = 0; i < 16; i++) begin
      append_cmd(lspq_pkg::OpInsert, fill_prio[i], 16'ha000 + 16'(i));
    end
    // Insert on a full queue must be dropped.
    append_cmd(lspq_pkg::OpInsert, 16'hffff, 16'h5a5a);
    append_cmd(lspq_pkg::OpExtract, 16'h0000, 16'h0000);
    append_cmd(lspq_pkg::OpExtract, 16'h0000, 16'h0000);

    // Random: phases lean toward filling or draining so full and empty both recur.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 40);
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      phase_left--;
      w.op = ($urandom_range(0, 99) < insert_pct) ? lspq_pkg::OpInsert : lspq_pkg::OpExtract;
      w.prio = pick_priority();
      w.tag = 16'($urandom);
      append_cmd(w.op, w.prio, w.tag);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || start || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("linear_scan_priority_queue verification clean");
    end else begin
      $display("linear_scan_priority_queue verification failed");
    end
    $finish;
  end

  // Timeout: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("linear_scan_priority_queue verification failed");
    $finish;
  end

endmodule
